// ===== sv/hptc_pkg.sv =====
package hptc_pkg;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_KP  = 2'd0,
    CFG_KI  = 2'd1,
    CFG_KD  = 2'd2,
    CFG_THR = 2'd3
  } cfg_idx_e;

  localparam int HeadW  = 13;
  localparam int TimeW  = 16;
  localparam int ErrW   = 13;
  localparam int IntW   = 14;
  localparam int DerW   = 14;
  localparam int GainW  = 16;
  localparam int ThrW   = 8;
  localparam int SpeedW = 11;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;
  localparam int WideW  = 15;
  localparam int ProdW  = 30;
  localparam int SumW   = 32;
  localparam int FracW  = 8;
  localparam int ShW    = SumW - FracW;

  localparam logic signed [WideW-1:0] HalfTurn = 15'sd2880;
  localparam logic signed [WideW-1:0] FullTurn = 15'sd5760;
  localparam logic signed [WideW-1:0] IntLimit = 15'sd6400;
  localparam logic signed [WideW-1:0] IntClear = 15'sd32;
  localparam logic signed [ShW-1:0]   SpeedLimit = 24'sd800;
  localparam logic [ThrW-1:0]         ThrReset = 8'd1;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic        [ThrW-1:0]  thr;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [IntW-1:0] integ;
    logic signed [DerW-1:0] deriv;
    logic                   brake;
  } track_t;

  typedef struct packed {
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] i;
    logic signed [ProdW-1:0] d;
    logic signed [ErrW-1:0]  err;
    logic                    brake;
  } prod_t;

endpackage

// ===== sv/heading_pid_turn_controller.sv =====
// Heading PID turn controller. A start beat latches the target heading and
// time limit, clears the integral and previous error and arms the loop; it
// yields no result. Each sample beat taken while armed yields one result
// beat with left/right drive (1/16 percent), the wrapped error (1/16 degree)
// and brake; samples while disarmed yield nothing. One beat is accepted per
// cycle while the input is not stalled. A result beat passes the input
// register (loaded at the accepting edge), the error/integral stage (where
// the loop state is updated as the beat enters it, so the next sample sees
// it), the multiplier stage and the output register.
// A stalled result holds the pipeline; the input stalls only once all four
// registers are full.
// Configuration registers: 0 kp, 1 ki, 2 kd (signed Q8.8), 3 settle
// threshold in whole degrees.
module heading_pid_turn_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [hptc_pkg::HeadW-1:0]         target_heading_i,
  input  logic [hptc_pkg::TimeW-1:0]         timeout_ms_i,
  input  logic [hptc_pkg::HeadW-1:0]         heading_i,
  input  logic [hptc_pkg::TimeW-1:0]         elapsed_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hptc_pkg::SpeedW-1:0] left_speed_o,
  output logic signed [hptc_pkg::SpeedW-1:0] right_speed_o,
  output logic signed [hptc_pkg::ErrW-1:0]   heading_error_o,
  output logic                               brake_o,
  input  logic                               cfg_we_i,
  input  logic [hptc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hptc_pkg::CfgW-1:0]          cfg_wdata_i
);
  import hptc_pkg::*;

  cfg_t   cfg;
  track_t trk;

  logic             in_v_q;
  op_e              op_q;
  logic [HeadW-1:0] tgt_q, head_q;
  logic [TimeW-1:0] tmo_q, elap_q;

  logic trk_v, drv_v;
  logic rdy0, rdy1, rdy2, rdy3;

  logic signed [SpeedW-1:0] drv_speed;
  logic signed [ErrW-1:0]   drv_err;
  logic                     drv_brake;

  logic                     out_v_q;
  logic signed [SpeedW-1:0] left_q, right_q;
  logic signed [ErrW-1:0]   err_q;
  logic                     brake_q;

  assign rdy3 = !out_v_q || !out_stall_i;
  assign rdy2 = !drv_v || rdy3;
  assign rdy1 = !trk_v || rdy2;
  assign rdy0 = !in_v_q || rdy1;
  assign in_stall_o = !rdy0;

  hptc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (rdy0) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      op_q   <= op_e'(operation_i);
      tgt_q  <= target_heading_i;
      tmo_q  <= timeout_ms_i;
      head_q <= heading_i;
      elap_q <= elapsed_ms_i;
    end
  end

  hptc_track u_track (
    .clk_i,
    .rst_ni,
    .valid_i          (in_v_q),
    .en_i             (rdy1),
    .operation_i      (op_q),
    .target_heading_i (tgt_q),
    .timeout_ms_i     (tmo_q),
    .heading_i        (head_q),
    .elapsed_ms_i     (elap_q),
    .thr_i            (cfg.thr),
    .valid_o          (trk_v),
    .trk_o            (trk)
  );

  hptc_drive u_drive (
    .clk_i,
    .rst_ni,
    .valid_i (trk_v),
    .en_i    (rdy2),
    .trk_i   (trk),
    .cfg_i   (cfg),
    .valid_o (drv_v),
    .speed_o (drv_speed),
    .err_o   (drv_err),
    .brake_o (drv_brake)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy3) begin
      out_v_q <= drv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && drv_v) begin
      left_q  <= drv_speed;
      right_q <= -drv_speed;
      err_q   <= drv_err;
      brake_q <= drv_brake;
    end
  end

  assign out_valid_o     = out_v_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign heading_error_o = err_q;
  assign brake_o         = brake_q;

endmodule

// ===== sv/hptc_cfg.sv =====
module hptc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hptc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hptc_pkg::CfgW-1:0]    cfg_wdata_i,
  output hptc_pkg::cfg_t               cfg_o
);
  import hptc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp  <= '0;
      cfg_q.ki  <= '0;
      cfg_q.kd  <= '0;
      cfg_q.thr <= ThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:  cfg_q.kp  <= cfg_wdata_i;
        CFG_KI:  cfg_q.ki  <= cfg_wdata_i;
        CFG_KD:  cfg_q.kd  <= cfg_wdata_i;
        CFG_THR: cfg_q.thr <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/hptc_track.sv =====
module hptc_track (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       en_i,
  input  hptc_pkg::op_e              operation_i,
  input  logic [hptc_pkg::HeadW-1:0] target_heading_i,
  input  logic [hptc_pkg::TimeW-1:0] timeout_ms_i,
  input  logic [hptc_pkg::HeadW-1:0] heading_i,
  input  logic [hptc_pkg::TimeW-1:0] elapsed_ms_i,
  input  logic [hptc_pkg::ThrW-1:0]  thr_i,
  output logic                       valid_o,
  output hptc_pkg::track_t           trk_o
);
  import hptc_pkg::*;

  logic                   armed_q;
  logic [HeadW-1:0]       target_q;
  logic [TimeW-1:0]       timeout_q;
  logic signed [IntW-1:0] integ_q;
  logic signed [ErrW-1:0] last_q;
  logic                   v_q;
  track_t                 trk_q;

  logic signed [WideW-1:0] diff, wrap1, wrap2, mag, isum, isat, deriv, thr16;
  logic                    fire, brake;
  track_t                  trk_d;

  always_comb begin
    diff  = $signed({2'b00, target_q}) - $signed({2'b00, heading_i});
    wrap1 = (diff > HalfTurn) ? diff - FullTurn : diff;
    wrap2 = (wrap1 < -HalfTurn) ? wrap1 + FullTurn : wrap1;
    mag   = (wrap2 < 0) ? -wrap2 : wrap2;
    isum  = WideW'(integ_q) + wrap2;
    if (isum > IntLimit) begin
      isat = IntLimit;
    end else if (isum < -IntLimit) begin
      isat = -IntLimit;
    end else begin
      isat = isum;
    end
    if (mag < IntClear) begin
      isat = '0;
    end
    deriv = wrap2 - WideW'(last_q);
    thr16 = $signed({3'b000, thr_i, 4'b0000});
    brake = (mag <= thr16) || (elapsed_ms_i >= timeout_q);
    trk_d.err   = wrap2[ErrW-1:0];
    trk_d.integ = isat[IntW-1:0];
    trk_d.deriv = deriv[DerW-1:0];
    trk_d.brake = brake;
  end

  assign fire = valid_i && en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      target_q  <= '0;
      timeout_q <= '0;
      integ_q   <= '0;
      last_q    <= '0;
    end else if (fire) begin
      if (operation_i == OP_START) begin
        target_q  <= target_heading_i;
        timeout_q <= timeout_ms_i;
        integ_q   <= '0;
        last_q    <= '0;
        armed_q   <= 1'b1;
      end else if (armed_q) begin
        integ_q <= trk_d.integ;
        last_q  <= trk_d.err;
        if (brake) begin
          armed_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i && (operation_i == OP_SAMPLE) && armed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trk_q <= trk_d;
    end
  end

  assign valid_o = v_q;
  assign trk_o   = trk_q;

endmodule

// ===== sv/hptc_drive.sv =====
module hptc_drive (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               en_i,
  input  hptc_pkg::track_t                   trk_i,
  input  hptc_pkg::cfg_t                     cfg_i,
  output logic                               valid_o,
  output logic signed [hptc_pkg::SpeedW-1:0] speed_o,
  output logic signed [hptc_pkg::ErrW-1:0]   err_o,
  output logic                               brake_o
);
  import hptc_pkg::*;

  logic  v_q;
  prod_t prod_q;
  prod_t prod_d;

  logic signed [SumW-1:0] sum;
  logic signed [ShW-1:0]  sh;

  always_comb begin
    prod_d.p     = ProdW'(cfg_i.kp) * ProdW'(trk_i.err);
    prod_d.i     = ProdW'(cfg_i.ki) * ProdW'(trk_i.integ);
    prod_d.d     = ProdW'(cfg_i.kd) * ProdW'(trk_i.deriv);
    prod_d.err   = trk_i.err;
    prod_d.brake = trk_i.brake;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // floor shift by the Q8.8 fraction, then clamp
  always_comb begin
    sum = SumW'(prod_q.p) + SumW'(prod_q.i) + SumW'(prod_q.d);
    sh  = sum[SumW-1:FracW];
    if (sh > SpeedLimit) begin
      speed_o = SpeedLimit[SpeedW-1:0];
    end else if (sh < -SpeedLimit) begin
      speed_o = -SpeedLimit[SpeedW-1:0];
    end else begin
      speed_o = sh[SpeedW-1:0];
    end
  end

  assign valid_o = v_q;
  assign err_o   = prod_q.err;
  assign brake_o = prod_q.brake;

endmodule

// ===== sv/hptc_checker.sv =====
module hptc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               operation_i,
  input logic [hptc_pkg::HeadW-1:0]         target_heading_i,
  input logic [hptc_pkg::TimeW-1:0]         timeout_ms_i,
  input logic [hptc_pkg::HeadW-1:0]         heading_i,
  input logic [hptc_pkg::TimeW-1:0]         elapsed_ms_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [hptc_pkg::SpeedW-1:0] left_speed_o,
  input logic signed [hptc_pkg::SpeedW-1:0] right_speed_o,
  input logic signed [hptc_pkg::ErrW-1:0]   heading_error_o,
  input logic                               brake_o
);
  import hptc_pkg::*;

  localparam logic signed [SpeedW-1:0] SpdMax = 11'sd800;
  localparam logic signed [ErrW-1:0]   ErrMax = 13'sd2880;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operation_i)
      && $stable(target_heading_i) && $stable(timeout_ms_i)
      && $stable(heading_i) && $stable(elapsed_ms_i))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_speed_o)
      && $stable(heading_error_o) && $stable(brake_o))
    else $error("result beat changed while stalled");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_speed_o == -left_speed_o)
    else $error("right speed is not the negated left speed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_speed_o <= SpdMax) && (left_speed_o >= -SpdMax))
    else $error("speed outside clamp");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_error_o <= ErrMax) && (heading_error_o >= -ErrMax))
    else $error("heading error not wrapped");

endmodule

bind heading_pid_turn_controller hptc_checker u_hptc_checker (.*);
